// ===== rtl/sdf_pkg.sv =====
// Shared types and constants for the serial sniffer deframer.
// No dependencies.
`timescale 1ns / 1ps

package sdf_pkg;

    localparam logic [7:0] VERSION_CMD = 8'h01;
    localparam logic [7:0] CMD_LENGTH  = 8'h00;
    localparam logic [7:0] CMD_CHANNEL = 8'h01;
    localparam logic [2:0] MAGIC_LEN   = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_CHANNEL = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
        logic [7:0] current_channel;
    } result_t;

    function automatic logic [7:0] magic_new(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0: m = 8'hC1;
            2'd1: m = 8'h1F;
            2'd2: m = 8'hFE;
            default: m = 8'h72;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] magic_old(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0: m = 8'h53;
            2'd1: m = 8'h6E;
            2'd2: m = 8'h69;
            default: m = 8'h66;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/sdf_in_stage.sv =====
// Input register for received bytes.
// Depends on nothing; the core drains it through advance.
`timescale 1ns / 1ps

module sdf_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       take;

    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

// ===== rtl/sdf_core.sv =====
// Deframing state machine: header hunt, command bytes, payload.
// Uses sdf_pkg for magic tables and the result type.
`timescale 1ns / 1ps

module sdf_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       byte_data,
    output logic             res_valid,
    output sdf_pkg::result_t res
);

    import sdf_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_CMD  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [2:0] index_reg, index_next;
    logic       match_new_reg, match_new_next;
    logic       match_legacy_reg, match_legacy_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] channel_reg, channel_next;

    always_comb
    begin
        logic [2:0] idx;
        logic       mn;
        logic       ml;
        logic       fin;

        phase_next        = phase_reg;
        index_next        = index_reg;
        match_new_next    = match_new_reg;
        match_legacy_next = match_legacy_reg;
        command_next      = command_reg;
        left_next         = left_reg;
        channel_next      = channel_reg;
        res_valid         = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.data          = byte_data;
        res.last          = 1'b0;
        res.current_channel = channel_reg;
        idx = index_reg;
        mn  = match_new_reg;
        ml  = match_legacy_reg;
        fin = (left_reg <= 8'd1);

        if (phase_reg == PH_PAY)
        begin
            res_valid = 1'b1;
            res.last  = fin;
            if (fin)
            begin
                left_next         = 8'd0;
                phase_next        = PH_HUNT;
                index_next        = 3'd0;
                match_new_next    = 1'b1;
                match_legacy_next = 1'b1;
            end
            else
            begin
                left_next = left_reg - 8'd1;
            end
        end
        else if (phase_reg == PH_CMD)
        begin
            if (index_reg == 3'd0)
            begin
                command_next = byte_data;
                index_next   = 3'd1;
            end
            else
            begin
                phase_next        = PH_HUNT;
                index_next        = 3'd0;
                match_new_next    = 1'b1;
                match_legacy_next = 1'b1;
                if (command_reg == CMD_CHANNEL)
                begin
                    channel_next        = byte_data;
                    res_valid           = 1'b1;
                    res.kind            = KIND_CHANNEL;
                    res.current_channel = byte_data;
                end
                else if (command_reg == CMD_LENGTH && byte_data != 8'd0)
                begin
                    left_next         = byte_data;
                    phase_next        = PH_PAY;
                    match_new_next    = match_new_reg;
                    match_legacy_next = match_legacy_reg;
                end
            end
        end
        else
        begin
            // unused phase code restarts the hunt before taking the byte
            if (phase_reg != PH_HUNT)
            begin
                idx = 3'd0;
                mn  = 1'b1;
                ml  = 1'b1;
            end
            phase_next        = PH_HUNT;
            index_next        = idx;
            match_new_next    = mn;
            match_legacy_next = ml;
            if (idx < MAGIC_LEN)
            begin
                if (byte_data != magic_new(idx[1:0]))
                begin
                    match_new_next = 1'b0;
                end
                if (byte_data != magic_old(idx[1:0]))
                begin
                    match_legacy_next = 1'b0;
                end
                index_next = idx + 3'd1;
            end
            else if (!mn && !ml)
            begin
                index_next        = 3'd0;
                match_new_next    = 1'b1;
                match_legacy_next = 1'b1;
            end
            else if (byte_data == VERSION_CMD)
            begin
                phase_next = PH_CMD;
                index_next = 3'd0;
            end
            else if (byte_data == 8'd0)
            begin
                index_next        = 3'd0;
                match_new_next    = 1'b1;
                match_legacy_next = 1'b1;
            end
            else
            begin
                left_next  = byte_data;
                phase_next = PH_PAY;
                index_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            index_reg        <= 3'd0;
            match_new_reg    <= 1'b1;
            match_legacy_reg <= 1'b1;
            command_reg      <= 8'd0;
            left_reg         <= 8'd0;
            channel_reg      <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            index_reg        <= index_next;
            match_new_reg    <= match_new_next;
            match_legacy_reg <= match_legacy_next;
            command_reg      <= command_next;
            left_reg         <= left_next;
            channel_reg      <= channel_next;
        end
    end

endmodule

// ===== rtl/sdf_out_stage.sv =====
// Result register with valid/stall handshake.
// Uses sdf_pkg for the result type.
`timescale 1ns / 1ps

module sdf_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sdf_pkg::result_t res,
    output logic             space,
    output logic             out_valid,
    input  logic             out_stall,
    output sdf_pkg::result_t out_res
);

    import sdf_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign space     = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== rtl/sniffer_serial_deframer.sv =====
// Serial sniffer deframer, top level.
// Data path: input register, then combinational core, then result register.
// Throughput: one byte per cycle unless a held result (out_stall) stalls the input.
// Reset: asynchronous active-low rst_n returns to header hunting, channel 0.
// Depends on sdf_pkg, sdf_in_stage, sdf_core, sdf_out_stage.
`timescale 1ns / 1ps

module sniffer_serial_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] data,
    output logic       last,
    output logic [7:0] current_channel
);

    import sdf_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       space;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    assign advance = byte_valid && space;

    sdf_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    sdf_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    sdf_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res       (res),
        .space     (space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind            = out_res.kind;
    assign data            = out_res.data;
    assign last            = out_res.last;
    assign current_channel = out_res.current_channel;

endmodule
